@@ hw/rtl/lks_pkg.sv @@
`default_nettype none

package lks_pkg;

  // Operation codes of a request
  localparam logic [2:0] OP_REQ_SETTING  = 3'd0;
  localparam logic [2:0] OP_REQ_KEYS     = 3'd1;
  localparam logic [2:0] OP_REQ_SEGMENTS = 3'd2;
  localparam logic [2:0] OP_WRITE_DIGIT  = 3'd3;
  localparam logic [2:0] OP_XFER_DONE    = 3'd4;

  // Active command codes as reported on the result
  localparam logic [1:0] CMD_IDLE     = 2'd0;
  localparam logic [1:0] CMD_SETTING  = 2'd1;
  localparam logic [1:0] CMD_KEYS     = 2'd2;
  localparam logic [1:0] CMD_SEGMENTS = 2'd3;

  // Pending bit positions
  localparam int PEND_SETTING  = 0;
  localparam int PEND_KEYS     = 1;
  localparam int PEND_SEGMENTS = 2;

  // Register indexes (register i at byte address 4*i)
  localparam logic REG_DISPLAY_ON = 1'b0;
  localparam logic REG_BRIGHTNESS = 1'b1;
  localparam int   PADDR_W        = 3;

  // Bytes on the serial line
  localparam logic [7:0] BYTE_SETTING   = 8'h80;
  localparam logic [7:0] BYTE_KEY_READ  = 8'h42;
  localparam logic [7:0] BYTE_AUTO_INC  = 8'h40;
  localparam logic [7:0] BYTE_ADDR_ZERO = 8'hC0;
  localparam logic [7:0] BYTE_DUMMY     = 8'hFF;

  // Digit limits
  localparam logic [3:0] MAX_DIGIT = 4'd7;
  localparam logic [7:0] MAX_VALUE = 8'd15;

  localparam int STEP_W      = 5;
  localparam int STORE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Command sequencer state
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_SETTING  = 4'b0010,
    ST_KEYS     = 4'b0100,
    ST_SEGMENTS = 4'b1000
  } cmd_state_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        digit;
    logic signed [7:0] value;
    logic [7:0]        received_byte;
  } req_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        frame_ended;
    logic        frame_started;
    logic        strobe_pulse;
    logic        data_line_released;
    logic [31:0] key_bits;
    logic        busy_res;
    logic [1:0]  active_cmd;
  } res_t;

  // Hex glyphs, segment a in bit 0
  function automatic logic [7:0] hex_glyph(input logic [3:0] v);
    logic [7:0] g;
    case (v)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/led_keypad_serial_sequencer.sv @@
`default_nettype none
// The result of an accepted request is registered and shows on res in the next cycle.
// Throughput: one request per cycle; the result register frees as it is taken,
// so cmd_stall only follows res_stall while a result is held.
// Reset (rst, synchronous): segment store and key word cleared, nothing pending,
// sequencer idle; display_on resets to 1 and brightness to 3.

module led_keypad_serial_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_stall,
  input  wire lks_pkg::req_t               cmd,
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output lks_pkg::res_t                    res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lks_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // Configuration registers
  logic       display_on;
  logic [2:0] brightness;

  // Sequencer state
  lks_pkg::cmd_state_t         state, state_next;
  logic [2:0]                  pending, pending_next;
  logic [lks_pkg::STEP_W-1:0]  step, step_next, step_m1;
  logic                        busy, busy_next;
  logic                        released, released_next;
  logic [23:0]                 collect, collect_next;
  logic [31:0]                 key_word, key_word_next;

  lks_pkg::res_t res_next;
  logic          take;
  logic          do_dispatch;
  logic          store_wr;
  logic [7:0]    store_byte;

  assign take      = cmd_valid && !cmd_stall;
  assign cmd_stall = res_valid && res_stall;
  assign pready    = 1'b1;

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      display_on <= 1'b1;
      brightness <= 3'd3;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        lks_pkg::REG_DISPLAY_ON: display_on <= pwdata[0];
        lks_pkg::REG_BRIGHTNESS: brightness <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lks_pkg::REG_DISPLAY_ON: prdata = {31'd0, display_on};
      lks_pkg::REG_BRIGHTNESS: prdata = {29'd0, brightness};
      default:                 prdata = 32'd0;
    endcase
  end

  // Segment store
  assign step_m1  = step - lks_pkg::STEP_W'(1);
  assign store_wr = take && (cmd.op == lks_pkg::OP_WRITE_DIGIT);

  lks_seg_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (store_wr),
    .digit   (cmd.digit),
    .value   (cmd.value),
    .rd_addr (step_m1[lks_pkg::ADDR_W-1:0]),
    .rd_data (store_byte)
  );

  // Next state and result of one request
  always_comb begin
    state_next    = state;
    pending_next  = pending;
    step_next     = step;
    busy_next     = busy;
    released_next = released;
    collect_next  = collect;
    key_word_next = key_word;
    do_dispatch   = 1'b0;
    res_next      = '0;

    case (cmd.op)
      lks_pkg::OP_REQ_SETTING, lks_pkg::OP_REQ_KEYS, lks_pkg::OP_REQ_SEGMENTS: begin
        pending_next = pending | (3'd1 << cmd.op[1:0]);
        do_dispatch  = !busy;
      end
      lks_pkg::OP_XFER_DONE: begin
        if (busy) begin
          if (step != '1) begin
            step_next = step + lks_pkg::STEP_W'(1);
          end
          unique case (state)
            lks_pkg::ST_KEYS: begin
              if (step == '0) begin
                released_next       = 1'b1;
                res_next.send_valid = 1'b1;
                res_next.send_byte  = lks_pkg::BYTE_DUMMY;
              end else if (step < lks_pkg::STEP_W'(4)) begin
                case (step[1:0])
                  2'd1:    collect_next[7:0]   = collect[7:0]   | cmd.received_byte;
                  2'd2:    collect_next[15:8]  = collect[15:8]  | cmd.received_byte;
                  default: collect_next[23:16] = collect[23:16] | cmd.received_byte;
                endcase
                res_next.send_valid = 1'b1;
                res_next.send_byte  = lks_pkg::BYTE_DUMMY;
              end else begin
                key_word_next        = {cmd.received_byte, collect};
                busy_next            = 1'b0;
                released_next        = 1'b0;
                res_next.frame_ended = 1'b1;
                do_dispatch          = 1'b1;
              end
            end
            lks_pkg::ST_SEGMENTS: begin
              if (step == '0) begin
                res_next.strobe_pulse = 1'b1;
                res_next.send_valid   = 1'b1;
                res_next.send_byte    = lks_pkg::BYTE_ADDR_ZERO;
              end else if (step <= lks_pkg::STEP_W'(lks_pkg::STORE_DEPTH)) begin
                res_next.send_valid = 1'b1;
                res_next.send_byte  = store_byte;
              end else begin
                busy_next            = 1'b0;
                released_next        = 1'b0;
                res_next.frame_ended = 1'b1;
                do_dispatch          = 1'b1;
              end
            end
            default: begin
              // setting write ends after its one byte
              busy_next            = 1'b0;
              released_next        = 1'b0;
              res_next.frame_ended = 1'b1;
              do_dispatch          = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase

    // Start the lowest pending command
    if (do_dispatch) begin
      step_next = '0;
      if (pending_next[lks_pkg::PEND_SETTING]) begin
        state_next                          = lks_pkg::ST_SETTING;
        pending_next[lks_pkg::PEND_SETTING] = 1'b0;
        busy_next                           = 1'b1;
        res_next.frame_started              = 1'b1;
        res_next.send_valid                 = 1'b1;
        res_next.send_byte = lks_pkg::BYTE_SETTING | {4'd0, display_on, brightness};
      end else if (pending_next[lks_pkg::PEND_KEYS]) begin
        state_next                       = lks_pkg::ST_KEYS;
        pending_next[lks_pkg::PEND_KEYS] = 1'b0;
        busy_next                        = 1'b1;
        collect_next                     = '0;
        res_next.frame_started           = 1'b1;
        res_next.send_valid              = 1'b1;
        res_next.send_byte               = lks_pkg::BYTE_KEY_READ;
      end else if (pending_next[lks_pkg::PEND_SEGMENTS]) begin
        state_next                           = lks_pkg::ST_SEGMENTS;
        pending_next[lks_pkg::PEND_SEGMENTS] = 1'b0;
        busy_next                            = 1'b1;
        res_next.frame_started               = 1'b1;
        res_next.send_valid                  = 1'b1;
        res_next.send_byte                   = lks_pkg::BYTE_AUTO_INC;
      end else begin
        state_next = lks_pkg::ST_IDLE;
        busy_next  = 1'b0;
      end
    end

    res_next.data_line_released = released_next;
    res_next.key_bits           = key_word_next;
    res_next.busy_res           = busy_next;
    unique case (state_next)
      lks_pkg::ST_SETTING:  res_next.active_cmd = lks_pkg::CMD_SETTING;
      lks_pkg::ST_KEYS:     res_next.active_cmd = lks_pkg::CMD_KEYS;
      lks_pkg::ST_SEGMENTS: res_next.active_cmd = lks_pkg::CMD_SEGMENTS;
      default:              res_next.active_cmd = lks_pkg::CMD_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lks_pkg::ST_IDLE;
      pending  <= '0;
      step     <= '0;
      busy     <= 1'b0;
      released <= 1'b0;
      collect  <= '0;
      key_word <= '0;
    end else if (take) begin
      state    <= state_next;
      pending  <= pending_next;
      step     <= step_next;
      busy     <= busy_next;
      released <= released_next;
      collect  <= collect_next;
      key_word <= key_word_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lks_seg_store.sv @@
`default_nettype none

module lks_seg_store (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [3:0]                 digit,
  input  wire logic [7:0]                 value,
  input  wire logic [lks_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                      rd_data
);

  logic [7:0] store [lks_pkg::STORE_DEPTH];
  logic [7:0] glyph;
  logic       digit_ok;

  // Blank for negative or out-of-range values
  always_comb begin
    glyph = 8'h00;
    if (!value[7] && value <= lks_pkg::MAX_VALUE) begin
      glyph = lks_pkg::hex_glyph(value[3:0]);
    end
  end

  assign digit_ok = (digit <= lks_pkg::MAX_DIGIT);

  // Glyph bit i lands in byte 2*i + digit[3], bit digit[2:0]
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < lks_pkg::STORE_DEPTH; e++) begin
        store[e] <= 8'h00;
      end
    end else if (wr_en && digit_ok) begin
      for (int e = 0; e < lks_pkg::STORE_DEPTH; e++) begin
        if (e[0] == digit[3]) begin
          store[e][digit[2:0]] <= glyph[e[3:1]];
        end
      end
    end
  end

  assign rd_data = store[rd_addr];

endmodule

`default_nettype wire
